[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each macro is empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every clock edge outside reset.
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that expr never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CHK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

[rtl/lcd4_pkg.sv]
`timescale 1ns / 1ps

package lcd4_pkg;

  // Request codes on the input side
  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_CMD   = 3'd1,
    OP_DATA  = 3'd2,
    OP_GOTO  = 3'd3,
    OP_CLEAR = 3'd4
  } lcd4_op_t;

  // Extra delay on the last step of a byte
  typedef enum logic [1:0] {
    EXTRA_NONE  = 2'd0,
    EXTRA_LONG  = 2'd1,
    EXTRA_CLEAR = 2'd2
  } lcd4_extra_t;

  localparam int HOLD_W = 13;
  localparam int STEP_W = 5;

  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] DDRAM_ROW1    = 8'h40;
  localparam logic [7:0] CMD_FUNC_4BIT = 8'h28;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [3:0] NIB_WAKE      = 4'h3;
  localparam logic [3:0] NIB_4BIT      = 4'h2;
  localparam logic [3:0] COL_MAX       = 4'd15;

  localparam logic [HOLD_W-1:0] HOLD_EN_HIGH = 13'd1;
  localparam logic [HOLD_W-1:0] HOLD_EN_LOW  = 13'd6;
  localparam logic [HOLD_W-1:0] HOLD_NIBBLE  = 13'd56;
  localparam logic [HOLD_W-1:0] HOLD_LONG    = 13'd2000;
  localparam logic [HOLD_W-1:0] HOLD_POWER   = 13'd2000;
  localparam logic [HOLD_W-1:0] HOLD_WAKE1   = 13'd5006;
  localparam logic [HOLD_W-1:0] HOLD_WAKE2   = 13'd106;
  localparam logic [HOLD_W-1:0] HOLD_NIB_LONG  = HOLD_NIBBLE + HOLD_LONG;
  localparam logic [HOLD_W-1:0] HOLD_NIB_CLEAR = HOLD_NIBBLE + HOLD_LONG + HOLD_LONG;

  localparam logic [STEP_W-1:0] INIT_LAST = 5'd24;
  localparam logic [STEP_W-1:0] BYTE_LAST = 5'd3;

  // One queued job for the back part
  typedef struct packed {
    logic        is_init;
    logic        rs;
    logic [7:0]  cmd_byte;
    lcd4_extra_t extra;
  } lcd4_job_t;

  // One pin step as it leaves the block
  typedef struct packed {
    logic              rs_pin;
    logic              en_pin;
    logic [3:0]        data_lines;
    logic [HOLD_W-1:0] hold_us;
    logic              last;
  } lcd4_step_t;

  // One entry of the power-up script; keep means leave the data lines as they are
  typedef struct packed {
    logic              en;
    logic              keep;
    logic [3:0]        nib;
    logic [HOLD_W-1:0] hold;
  } lcd4_init_ent_t;

  function automatic lcd4_init_ent_t init_step(input logic [STEP_W-1:0] idx);
    lcd4_init_ent_t e;
    e = '{en: 1'b0, keep: 1'b0, nib: 4'h0, hold: HOLD_NIBBLE};
    case (idx)
      5'd0:  e = '{en: 1'b0, keep: 1'b1, nib: 4'h0, hold: HOLD_POWER};
      5'd1:  e = '{en: 1'b1, keep: 1'b0, nib: NIB_WAKE, hold: HOLD_EN_HIGH};
      5'd2:  e = '{en: 1'b0, keep: 1'b0, nib: NIB_WAKE, hold: HOLD_WAKE1};
      5'd3:  e = '{en: 1'b1, keep: 1'b0, nib: NIB_WAKE, hold: HOLD_EN_HIGH};
      5'd4:  e = '{en: 1'b0, keep: 1'b0, nib: NIB_WAKE, hold: HOLD_WAKE2};
      5'd5:  e = '{en: 1'b1, keep: 1'b0, nib: NIB_WAKE, hold: HOLD_EN_HIGH};
      5'd6:  e = '{en: 1'b0, keep: 1'b0, nib: NIB_WAKE, hold: HOLD_WAKE2};
      5'd7:  e = '{en: 1'b1, keep: 1'b0, nib: NIB_4BIT, hold: HOLD_EN_HIGH};
      5'd8:  e = '{en: 1'b0, keep: 1'b0, nib: NIB_4BIT, hold: HOLD_EN_LOW};
      5'd9:  e = '{en: 1'b1, keep: 1'b0, nib: CMD_FUNC_4BIT[7:4], hold: HOLD_EN_HIGH};
      5'd10: e = '{en: 1'b0, keep: 1'b0, nib: CMD_FUNC_4BIT[7:4], hold: HOLD_NIBBLE};
      5'd11: e = '{en: 1'b1, keep: 1'b0, nib: CMD_FUNC_4BIT[3:0], hold: HOLD_EN_HIGH};
      5'd12: e = '{en: 1'b0, keep: 1'b0, nib: CMD_FUNC_4BIT[3:0], hold: HOLD_NIBBLE};
      5'd13: e = '{en: 1'b1, keep: 1'b0, nib: CMD_DISP_ON[7:4], hold: HOLD_EN_HIGH};
      5'd14: e = '{en: 1'b0, keep: 1'b0, nib: CMD_DISP_ON[7:4], hold: HOLD_NIBBLE};
      5'd15: e = '{en: 1'b1, keep: 1'b0, nib: CMD_DISP_ON[3:0], hold: HOLD_EN_HIGH};
      5'd16: e = '{en: 1'b0, keep: 1'b0, nib: CMD_DISP_ON[3:0], hold: HOLD_NIBBLE};
      5'd17: e = '{en: 1'b1, keep: 1'b0, nib: CMD_ENTRY[7:4], hold: HOLD_EN_HIGH};
      5'd18: e = '{en: 1'b0, keep: 1'b0, nib: CMD_ENTRY[7:4], hold: HOLD_NIBBLE};
      5'd19: e = '{en: 1'b1, keep: 1'b0, nib: CMD_ENTRY[3:0], hold: HOLD_EN_HIGH};
      5'd20: e = '{en: 1'b0, keep: 1'b0, nib: CMD_ENTRY[3:0], hold: HOLD_NIBBLE};
      5'd21: e = '{en: 1'b1, keep: 1'b0, nib: CMD_CLEAR[7:4], hold: HOLD_EN_HIGH};
      5'd22: e = '{en: 1'b0, keep: 1'b0, nib: CMD_CLEAR[7:4], hold: HOLD_NIBBLE};
      5'd23: e = '{en: 1'b1, keep: 1'b0, nib: CMD_CLEAR[3:0], hold: HOLD_EN_HIGH};
      5'd24: e = '{en: 1'b0, keep: 1'b0, nib: CMD_CLEAR[3:0], hold: HOLD_NIB_CLEAR};
      default: e = '{en: 1'b0, keep: 1'b1, nib: 4'h0, hold: HOLD_NIBBLE};
    endcase
    return e;
  endfunction

endpackage

[rtl/lcd4_fifo.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lcd4_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] dout,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `ASSERT_CHK(a_count_bound, clk, rst_n, count_r <= CNT_FULL, "fifo count past depth")
  `ASSERT_CHK(a_ptr_gap, clk, rst_n, (count_r == '0 || count_r == CNT_FULL) |-> wr_ptr_r == rd_ptr_r, "fifo pointers disagree with count")

endmodule

[rtl/lcd4_front.sv]
`timescale 1ns / 1ps

module lcd4_front (
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           in_op,
  input  logic [7:0]           in_value,
  input  logic [7:0]           in_col,
  input  logic [7:0]           in_row,
  output logic                 job_push,
  output lcd4_pkg::lcd4_job_t  job,
  input  logic                 job_full
);

  logic       known;
  logic [3:0] col_c;
  logic [7:0] goto_cmd;
  logic       long_cmd;

  // Clamp the cursor position and build the set-address command
  assign col_c    = (in_col > {4'h0, lcd4_pkg::COL_MAX}) ? lcd4_pkg::COL_MAX : in_col[3:0];
  assign goto_cmd = lcd4_pkg::CMD_SET_DDRAM |
                    (((in_row != 8'h00) ? lcd4_pkg::DDRAM_ROW1 : 8'h00) + {4'h0, col_c});
  assign long_cmd = (in_value == lcd4_pkg::CMD_CLEAR) || (in_value == lcd4_pkg::CMD_HOME);

  always_comb begin
    known = 1'b1;
    job   = '{is_init: 1'b0, rs: 1'b0, cmd_byte: in_value, extra: lcd4_pkg::EXTRA_NONE};
    case (lcd4_pkg::lcd4_op_t'(in_op))
      lcd4_pkg::OP_INIT: begin
        job.is_init = 1'b1;
      end
      lcd4_pkg::OP_CMD: begin
        job.extra = long_cmd ? lcd4_pkg::EXTRA_LONG : lcd4_pkg::EXTRA_NONE;
      end
      lcd4_pkg::OP_DATA: begin
        job.rs = 1'b1;
      end
      lcd4_pkg::OP_GOTO: begin
        job.cmd_byte = goto_cmd;
      end
      lcd4_pkg::OP_CLEAR: begin
        job.cmd_byte = lcd4_pkg::CMD_CLEAR;
        job.extra    = lcd4_pkg::EXTRA_CLEAR;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Unknown requests are taken and dropped
  assign full     = job_full;
  assign job_push = push && !job_full && known;

endmodule

[rtl/lcd4_back.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lcd4_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcd4_pkg::lcd4_job_t  job,
  input  logic                 job_valid,
  output logic                 job_pop,
  output logic                 step_push,
  output lcd4_pkg::lcd4_step_t step,
  input  logic                 step_full
);

  logic [lcd4_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [3:0]                  nib_r, nib_nxt;
  logic [lcd4_pkg::STEP_W-1:0] last_idx;
  logic [lcd4_pkg::HOLD_W-1:0] tail_hold;
  lcd4_pkg::lcd4_init_ent_t    ent;
  logic [1:0]                  k;
  logic                        step_last;

  assign ent = lcd4_pkg::init_step(step_r);
  assign k   = step_r[1:0];

  always_comb begin
    case (job.extra)
      lcd4_pkg::EXTRA_NONE:  tail_hold = lcd4_pkg::HOLD_NIBBLE;
      lcd4_pkg::EXTRA_LONG:  tail_hold = lcd4_pkg::HOLD_NIB_LONG;
      lcd4_pkg::EXTRA_CLEAR: tail_hold = lcd4_pkg::HOLD_NIB_CLEAR;
      default:               tail_hold = lcd4_pkg::HOLD_NIBBLE;
    endcase
  end

  always_comb begin
    if (job.is_init) begin
      last_idx        = lcd4_pkg::INIT_LAST;
      step.rs_pin     = 1'b0;
      step.en_pin     = ent.en;
      step.data_lines = ent.keep ? nib_r : ent.nib;
      step.hold_us    = ent.hold;
    end else begin
      // steps: high nibble EN high, EN low, then low nibble EN high, EN low
      last_idx        = lcd4_pkg::BYTE_LAST;
      step.rs_pin     = job.rs;
      step.en_pin     = !k[0];
      step.data_lines = k[1] ? job.cmd_byte[3:0] : job.cmd_byte[7:4];
      step.hold_us    = k[0] ? (k[1] ? tail_hold : lcd4_pkg::HOLD_NIBBLE)
                             : lcd4_pkg::HOLD_EN_HIGH;
    end
    step_last = (step_r == last_idx);
    step.last = step_last;
  end

  assign step_push = job_valid && !step_full;
  assign job_pop   = step_push && step_last;

  always_comb begin
    step_nxt = step_r;
    nib_nxt  = nib_r;
    if (step_push) begin
      step_nxt = step_last ? '0 : step_r + lcd4_pkg::STEP_W'(1);
      nib_nxt  = step.data_lines;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      nib_r  <= '0;
    end else begin
      step_r <= step_nxt;
      nib_r  <= nib_nxt;
    end
  end

  `ASSERT_CHK(a_idle_step_zero, clk, rst_n, !job_valid |-> step_r == '0, "step counter moved with no job")
  `ASSERT_CHK(a_wrap_after_last, clk, rst_n, job_pop |=> step_r == '0, "step counter not cleared after run")

endmodule

[rtl/char_lcd_nibble_write_sequencer.sv]
`timescale 1ns / 1ps

// Character LCD 4-bit write sequencer. Each request word (init, command byte,
// data byte, cursor goto, clear) turns into a run of pin-step words: RS, EN,
// D4..D7 and a hold time in microseconds, with last set on the final step of
// the run. A byte request gives 4 steps (high nibble first, EN high 1us then
// EN low 56us per nibble); init gives the 25-step power-up script. Commands
// 0x01 and 0x02 stretch the final hold by 2000us, clear by 4000us; unknown
// request codes are taken and give no steps. The front classifies a request
// in the cycle it is pushed and places one job in the job queue; a request is
// taken every cycle while that queue has room. The back walks the head job
// with a step counter and emits one step per cycle into the result queue
// while the result queue has room; that counter sets the sustained rate.
// The result queue lets the back keep going while a finished step waits to
// be popped.
module char_lcd_nibble_write_sequencer #(
  parameter int JOB_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_value,
  input  logic [7:0]  in_col,
  input  logic [7:0]  in_row,
  output logic        empty,
  input  logic        pop,
  output logic        out_rs_pin,
  output logic        out_en_pin,
  output logic [3:0]  out_data_lines,
  output logic [12:0] out_hold_us,
  output logic        out_last
);

  localparam int JOB_W  = $bits(lcd4_pkg::lcd4_job_t);
  localparam int STEP_W = $bits(lcd4_pkg::lcd4_step_t);

  lcd4_pkg::lcd4_job_t  fe_job, q_job;
  lcd4_pkg::lcd4_step_t be_step, q_step;
  logic                 fe_push, job_full, job_empty, job_pop;
  logic                 step_push, step_full;

  // Front: classify the request word, drop unknown codes
  lcd4_front u_front (
    .push     (push),
    .full     (full),
    .in_op    (in_op),
    .in_value (in_value),
    .in_col   (in_col),
    .in_row   (in_row),
    .job_push (fe_push),
    .job      (fe_job),
    .job_full (job_full)
  );

  // Job queue between front and back
  lcd4_fifo #(
    .DATA_W (JOB_W),
    .DEPTH  (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .din   (fe_job),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (q_job),
    .empty (job_empty)
  );

  // Back: advance through the steps of the head job
  lcd4_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (q_job),
    .job_valid (!job_empty),
    .job_pop   (job_pop),
    .step_push (step_push),
    .step      (be_step),
    .step_full (step_full)
  );

  // Result queue: hold finished steps until popped
  lcd4_fifo #(
    .DATA_W (STEP_W),
    .DEPTH  (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (step_push),
    .din   (be_step),
    .full  (step_full),
    .pop   (pop),
    .dout  (q_step),
    .empty (empty)
  );

  assign out_rs_pin     = q_step.rs_pin;
  assign out_en_pin     = q_step.en_pin;
  assign out_data_lines = q_step.data_lines;
  assign out_hold_us    = q_step.hold_us;
  assign out_last       = q_step.last;

endmodule
